/* hw/rtl/cisw_pkg.sv */
// Shared constants and types for the chunked image stop-and-wait sender.
// No dependencies; used by chunked_image_stop_and_wait_sender_unit.
`timescale 1ns / 1ps
`default_nettype none

package cisw_pkg;

  // Packet framing
  localparam logic [15:0] PKT_MAGIC = 16'hF17E;
  localparam int          HDR_BYTES = 10;

  // Field widths fixed by the interface
  localparam int LEN_W   = 14;
  localparam int CHUNK_W = 16;
  localparam int MISS_W  = 32;
  localparam int LADDR_W = 13;

  // Input item function codes
  typedef enum logic [1:0] {
    FUNC_TICK = 2'd0,
    FUNC_ACK  = 2'd1,
    FUNC_LOAD = 2'd2
  } func_e;

endpackage

`default_nettype wire

/* hw/rtl/chunked_image_stop_and_wait_sender_unit.sv */
// Stop-and-wait sender: image store, chunk summing, packet framing, retry count.
// Depends on cisw_pkg for framing constants and function codes.
// Timing: load, ack and unused items leave the block idle; a status result strobes the cycle
// after its tick. A first send sums the chunk through the single store read port into
// the one accumulator, then emits 10+len bytes, one a cycle; a retry skips the sum.
// Results cannot be stalled. A config write is taken while idle and no item is
// presented; a reciprocal multiply gives the chunk count.
// Reset clears all control state; the image store holds garbage until loaded.
`timescale 1ns / 1ps
`default_nettype none

module chunked_image_stop_and_wait_sender_unit #(
  parameter int IMAGE_DEPTH = 8192,
  parameter int CHUNK_BYTES = 48
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // command channel
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [1:0]                  func_i,
  input  wire logic                        reachable_i,
  input  wire logic [15:0]                 ack_number_i,
  input  wire logic [12:0]                 load_address_i,
  input  wire logic [7:0]                  load_byte_i,
  // configuration write channel (image_length)
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [13:0]                 cfg_data_i,
  // result channel, one item per strobe
  output logic                             strobe_o,
  output logic                             kind_o,
  output logic [7:0]                       packet_byte_o,
  output logic                             last_o,
  output logic                             resend_o,
  output logic                             transfer_done_o,
  output logic                             short_wait_o,
  output logic [15:0]                      chunk_number_o,
  output logic [31:0]                      missed_count_o
);

  // Widths derived from the parameters
  localparam int AW  = $clog2(IMAGE_DEPTH);                        // store index
  localparam int RAW = $clog2((1 << cisw_pkg::LEN_W) + cisw_pkg::HDR_BYTES
                              + CHUNK_BYTES);                      // read address sum
  localparam int LW  = $clog2(CHUNK_BYTES + 1);                    // chunk length
  localparam int CW  = $clog2(cisw_pkg::HDR_BYTES + CHUNK_BYTES + 1); // step counter
  localparam int LADDR_PAD = cisw_pkg::LADDR_W + 2;

  // Chunk count by reciprocal multiplication: exact for every numerator below 2^QN
  localparam int QN  = cisw_pkg::LEN_W + 1;                        // numerator bits
  localparam int QS  = QN + $clog2(CHUNK_BYTES);                   // reciprocal shift
  localparam int QMW = QN + 1;                                     // reciprocal bits
  localparam int PW  = QN + QMW;                                   // product bits
  localparam logic [QMW-1:0] QM = QMW'(((1 << QS) + CHUNK_BYTES - 1) / CHUNK_BYTES);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_EMIT
  } st_e;

  // ------------------------------------------------------------------
  // State
  // ------------------------------------------------------------------
  st_e                        st_q;
  logic [CW-1:0]              cnt_q;
  logic [cisw_pkg::LEN_W-1:0] length_q;
  logic [7:0]                 total_q;
  logic                       waiting_q;
  logic                       ack_seen_q;
  logic [cisw_pkg::CHUNK_W-1:0] chunk_q;
  logic [cisw_pkg::LEN_W-1:0] offset_q;
  logic [cisw_pkg::MISS_W-1:0] miss_q;
  logic [15:0]                sum_q;
  logic                       pkt_resend_q;

  // registered result item
  logic       strobe_q;
  logic       kind_q;
  logic [7:0] byte_q;
  logic       last_q;
  logic       resend_q;
  logic       short_q;

  // image store and its read port
  logic [7:0] mem [IMAGE_DEPTH];
  logic [7:0] mem_q;
  logic       rd_ok_q;

  // ------------------------------------------------------------------
  // Combinational helpers
  // ------------------------------------------------------------------
  logic                       accept;
  logic                       cfg_wr;
  logic [cisw_pkg::LEN_W-1:0] rem_len;
  logic [LW-1:0]              cur_len;
  logic [CW-1:0]              rd_idx;
  logic [RAW-1:0]             rd_addr;
  logic                       rd_in;
  logic [7:0]                 rd_data;
  logic [7:0]                 hdr_byte;
  logic [CW-1:0]              last_cnt;
  logic [QN-1:0]              quo_num;
  logic [PW-1:0]              quo_prod;
  logic [7:0]                 total_d;
  logic [LADDR_PAD-1:0]       wr_addr;
  logic                       wr_en;

  assign accept = start && !busy;
  assign cfg_wr = cfg_valid_i && cfg_ready_o;

  // Chunk length: what is left of the image, capped at one chunk.
  // Only meaningful while the offset is below the image length.
  always_comb begin
    rem_len = length_q - offset_q;
    if (rem_len > cisw_pkg::LEN_W'(CHUNK_BYTES)) begin
      cur_len = LW'(CHUNK_BYTES);
    end else begin
      cur_len = rem_len[LW-1:0];
    end
  end

  // Store read address. While summing, the counter is the payload index; while
  // emitting, fetch one byte ahead so the data lands as the byte goes out.
  always_comb begin
    if (st_q == ST_SUM) begin
      rd_idx = cnt_q;
    end else begin
      rd_idx = cnt_q - CW'(cisw_pkg::HDR_BYTES - 1);
    end
    rd_addr = RAW'(offset_q) + RAW'(rd_idx);
    rd_in   = rd_addr < RAW'(IMAGE_DEPTH);
  end

  // Reads beyond the store return zero.
  assign rd_data = rd_ok_q ? mem_q : 8'h00;

  // Header byte mux, indexed by the emit counter
  always_comb begin
    case (cnt_q)
      CW'(0):  hdr_byte = cisw_pkg::PKT_MAGIC[15:8];
      CW'(1):  hdr_byte = cisw_pkg::PKT_MAGIC[7:0];
      CW'(2):  hdr_byte = chunk_q[15:8];
      CW'(3):  hdr_byte = chunk_q[7:0];
      CW'(4):  hdr_byte = 8'(offset_q >> 8);
      CW'(5):  hdr_byte = offset_q[7:0];
      CW'(6):  hdr_byte = 8'(cur_len);
      CW'(7):  hdr_byte = total_q;
      CW'(8):  hdr_byte = sum_q[15:8];
      default: hdr_byte = sum_q[7:0];
    endcase
  end

  assign last_cnt = CW'(cisw_pkg::HDR_BYTES) + CW'(cur_len) - CW'(1);

  // Total chunk count, ceil(length / chunk); keep only the low 8 bits
  assign quo_num  = QN'(cfg_data_i) + QN'(CHUNK_BYTES - 1);
  assign quo_prod = PW'(quo_num) * PW'(QM);
  assign total_d  = quo_prod[QS +: 8];

  // Load decode
  assign wr_addr = LADDR_PAD'(load_address_i);
  assign wr_en   = accept && (func_i == cisw_pkg::FUNC_LOAD)
                   && (wr_addr < LADDR_PAD'(IMAGE_DEPTH));

  // ------------------------------------------------------------------
  // Image store: one write port (loads), one registered read port
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr[AW-1:0]] <= load_byte_i;
    end
    if (rd_in) begin
      mem_q <= mem[rd_addr[AW-1:0]];
    end
    rd_ok_q <= rd_in;
  end

  // ------------------------------------------------------------------
  // Sequencer, protocol state and result register
  // ------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= ST_IDLE;
      cnt_q        <= '0;
      length_q     <= '0;
      total_q      <= '0;
      waiting_q    <= 1'b0;
      ack_seen_q   <= 1'b0;
      chunk_q      <= '0;
      offset_q     <= '0;
      miss_q       <= '0;
      sum_q        <= '0;
      pkt_resend_q <= 1'b0;
      strobe_q     <= 1'b0;
      kind_q       <= 1'b0;
      byte_q       <= '0;
      last_q       <= 1'b0;
      resend_q     <= 1'b0;
      short_q      <= 1'b0;
    end else begin
      // drop the strobe unless a result is produced this cycle
      strobe_q <= 1'b0;

      unique case (st_q)
        ST_IDLE: begin
          if (cfg_wr) begin
            // latch length and its chunk count
            length_q <= cfg_data_i;
            total_q  <= total_d;
          end else if (accept) begin
            case (func_i)
              cisw_pkg::FUNC_ACK: begin
                if (ack_number_i == chunk_q) begin
                  ack_seen_q <= 1'b1;
                end
              end
              cisw_pkg::FUNC_TICK: begin
                // default: one status item
                strobe_q <= 1'b1;
                kind_q   <= 1'b1;
                byte_q   <= '0;
                last_q   <= 1'b1;
                resend_q <= 1'b0;
                short_q  <= 1'b0;
                if (!reachable_i) begin
                  if (offset_q != '0) begin
                    miss_q <= miss_q + 1'b1;
                  end
                end else if (offset_q >= length_q) begin
                  // transfer complete: status only, nothing changes
                end else if (!waiting_q) begin
                  // first send: sum the chunk, then emit
                  strobe_q     <= 1'b0;
                  ack_seen_q   <= 1'b0;
                  waiting_q    <= 1'b1;
                  pkt_resend_q <= 1'b0;
                  sum_q        <= '0;
                  cnt_q        <= '0;
                  st_q         <= ST_SUM;
                end else if (ack_seen_q) begin
                  // advance to the next chunk
                  offset_q  <= offset_q + cisw_pkg::LEN_W'(cur_len);
                  chunk_q   <= chunk_q + 1'b1;
                  waiting_q <= 1'b0;
                  short_q   <= 1'b1;
                end else begin
                  // retransmit with the saved sum
                  strobe_q     <= 1'b0;
                  miss_q       <= miss_q + 1'b1;
                  pkt_resend_q <= 1'b1;
                  cnt_q        <= '0;
                  st_q         <= ST_EMIT;
                end
              end
              default: begin
                // load is handled by the store; unused code does nothing
              end
            endcase
          end
        end

        ST_SUM: begin
          // add the byte fetched last cycle; the first cycle only fetches
          if (cnt_q != '0) begin
            sum_q <= sum_q + 16'(rd_data);
          end
          if (cnt_q == CW'(cur_len)) begin
            cnt_q <= '0;
            st_q  <= ST_EMIT;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end

        ST_EMIT: begin
          // header first, then payload from the store
          strobe_q <= 1'b1;
          kind_q   <= 1'b0;
          resend_q <= pkt_resend_q;
          short_q  <= 1'b0;
          if (cnt_q < CW'(cisw_pkg::HDR_BYTES)) begin
            byte_q <= hdr_byte;
          end else begin
            byte_q <= rd_data;
          end
          if (cnt_q == last_cnt) begin
            last_q <= 1'b1;
            cnt_q  <= '0;
            st_q   <= ST_IDLE;
          end else begin
            last_q <= 1'b0;
            cnt_q  <= cnt_q + 1'b1;
          end
        end

        default: begin
          st_q <= ST_IDLE;
        end
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Outputs
  // ------------------------------------------------------------------
  assign busy        = (st_q != ST_IDLE);
  // a pending item takes the idle cycle; hold the write off until it is gone
  assign cfg_ready_o = (st_q == ST_IDLE) && !start;

  assign strobe_o        = strobe_q;
  assign kind_o          = kind_q;
  assign packet_byte_o   = byte_q;
  assign last_o          = last_q;
  assign resend_o        = resend_q;
  assign short_wait_o    = short_q;
  // protocol state is frozen while results stream, so show it directly
  assign transfer_done_o = (offset_q >= length_q);
  assign chunk_number_o  = chunk_q;
  assign missed_count_o  = miss_q;

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// Self-checking bench for chunked_image_stop_and_wait_sender_unit: framed packet bytes,
// status results, retries and miss counts, checked against an in-bench predictor.
// Depends on cisw_pkg and the sender unit; needs no other file.
`timescale 1ns / 1ps

module tb_top;

  localparam int IMAGE_DEPTH   = 8192;
  localparam int CHUNK_BYTES   = 48;
  localparam int SETTLE_CYCLES = 8;                  // loads and acks leave the block idle
  localparam int TAIL_CYCLES   = 2 * CHUNK_BYTES + 24;
  localparam int ITEM_TARGET   = 160;                // input items over the whole run
  localparam int PHASE_MIN     = 4;                  // random items in every phase at least

  // func code the block must ignore
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // One command item as the driver presents it
  typedef struct packed {
    logic [1:0]                   func;
    logic                         reachable;
    logic [cisw_pkg::CHUNK_W-1:0] ack_number;
    logic [cisw_pkg::LADDR_W-1:0] load_address;
    logic [7:0]                   load_byte;
  } cmd_t;

  // Control state of the link: everything except the image bytes and the saved sum
  typedef struct packed {
    logic [cisw_pkg::LEN_W-1:0]   length;
    logic                         waiting;
    logic                         ack_seen;
    logic [cisw_pkg::CHUNK_W-1:0] chunk;
    logic [cisw_pkg::LEN_W-1:0]   offset;
    logic [cisw_pkg::MISS_W-1:0]  misses;
  } link_state_t;

  // One result item on the output ports
  typedef struct packed {
    logic                         kind;
    logic [7:0]                   pbyte;
    logic                         last;
    logic                         resend;
    logic                         xfer_done;
    logic                         short_wait;
    logic [cisw_pkg::CHUNK_W-1:0] chunk;
    logic [cisw_pkg::MISS_W-1:0]  misses;
  } tx_t;

  typedef enum {ACT_QUIET, ACT_STATUS, ACT_SEND, ACT_ADVANCE, ACT_RESEND} tick_act_e;

  // DUT ports; every input starts at a known value
  logic                       clk_i          = 1'b0;
  logic                       rst_ni         = 1'b0;
  logic                       start          = 1'b0;
  logic                       busy;
  logic [1:0]                 func_i         = cisw_pkg::FUNC_LOAD;
  logic                       reachable_i    = 1'b0;
  logic [15:0]                ack_number_i   = '0;
  logic [12:0]                load_address_i = '0;
  logic [7:0]                 load_byte_i    = '0;
  logic                       cfg_valid_i    = 1'b0;
  logic                       cfg_ready_o;
  logic [cisw_pkg::LEN_W-1:0] cfg_data_i     = '0;
  logic                       strobe_o;
  logic                       kind_o;
  logic [7:0]                 packet_byte_o;
  logic                       last_o;
  logic                       resend_o;
  logic                       transfer_done_o;
  logic                       short_wait_o;
  logic [15:0]                chunk_number_o;
  logic [31:0]                missed_count_o;

  // Bench state
  cmd_t        cmd_q[$];                 // items waiting for the driver
  tx_t         tx_awaited_q[$];          // packet bytes and status results still to come
  link_state_t mirror = '0;              // predictor copy, advanced on accepted items
  link_state_t plan   = '0;              // generator copy, advanced as items are queued
  logic [15:0] mirror_sum = '0;          // byte sum saved at first send of a chunk
  logic [7:0]  img_mem [IMAGE_DEPTH];
  bit          loaded [IMAGE_DEPTH];     // bytes the generator has written so far
  cmd_t        cur_cmd;
  int          gap_left     = 0;
  bit          idle_ok      = 1'b1;
  int          mismatches   = 0;
  int          queued_items = 0;         // every item queued, filler loads included

  chunked_image_stop_and_wait_sender_unit #(
    .IMAGE_DEPTH(IMAGE_DEPTH),
    .CHUNK_BYTES(CHUNK_BYTES)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .func_i         (func_i),
    .reachable_i    (reachable_i),
    .ack_number_i   (ack_number_i),
    .load_address_i (load_address_i),
    .load_byte_i    (load_byte_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .strobe_o       (strobe_o),
    .kind_o         (kind_o),
    .packet_byte_o  (packet_byte_o),
    .last_o         (last_o),
    .resend_o       (resend_o),
    .transfer_done_o(transfer_done_o),
    .short_wait_o   (short_wait_o),
    .chunk_number_o (chunk_number_o),
    .missed_count_o (missed_count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ------------------------------------------------------------------
  // Link behavior
  // ------------------------------------------------------------------

  // Payload length of the current chunk; only meaningful while offset < length.
  function automatic int chunk_len(link_state_t s);
    int rem;
    rem = int'(s.length) - int'(s.offset);
    return (rem > CHUNK_BYTES) ? CHUNK_BYTES : rem;
  endfunction

  // Decide what a tick does in state s; anything but a tick is quiet.
  function automatic tick_act_e tick_action(link_state_t s, cmd_t c);
    if (c.func != cisw_pkg::FUNC_TICK) return ACT_QUIET;
    if (!c.reachable || s.offset >= s.length) return ACT_STATUS;
    if (!s.waiting) return ACT_SEND;
    if (s.ack_seen) return ACT_ADVANCE;
    return ACT_RESEND;
  endfunction

  function automatic link_state_t next_state(link_state_t s, cmd_t c);
    link_state_t r;
    r = s;
    if (c.func == cisw_pkg::FUNC_ACK) begin
      // a matching ack arms the advance in either state
      if (c.ack_number == s.chunk) r.ack_seen = 1'b1;
    end else if (c.func == cisw_pkg::FUNC_TICK) begin
      case (tick_action(s, c))
        ACT_SEND: begin
          r.ack_seen = 1'b0;
          r.waiting  = 1'b1;
        end
        ACT_ADVANCE: begin
          r.offset  = s.offset + cisw_pkg::LEN_W'(chunk_len(s));
          r.chunk   = s.chunk + 1'b1;
          r.waiting = 1'b0;
        end
        ACT_RESEND: r.misses = s.misses + 1'b1;
        ACT_STATUS: begin
          // unreachable ticks count as misses once the transfer has begun
          if (!c.reachable && s.offset != '0) r.misses = s.misses + 1'b1;
        end
        default: ;
      endcase
    end
    return r;
  endfunction

  // Work out the results of one accepted item and queue them in order.
  function automatic void predict_tx(cmd_t c);
    link_state_t nxt;
    tick_act_e   act;
    logic [7:0]  hdr [cisw_pkg::HDR_BYTES];
    tx_t         t;
    int          len, total, i;
    act = tick_action(mirror, c);
    nxt = next_state(mirror, c);
    if (c.func == cisw_pkg::FUNC_LOAD) img_mem[c.load_address] = c.load_byte;
    // the sum is taken once, on first send; a retry reuses it
    if (act == ACT_SEND) begin
      mirror_sum = '0;
      for (i = 0; i < chunk_len(mirror); i++) mirror_sum += img_mem[int'(mirror.offset) + i];
    end
    t.xfer_done  = (nxt.offset >= nxt.length);
    t.chunk      = nxt.chunk;
    t.misses     = nxt.misses;
    t.resend     = (act == ACT_RESEND);
    t.short_wait = (act == ACT_ADVANCE);
    if (act == ACT_SEND || act == ACT_RESEND) begin
      // length, total and payload come from the current register and store
      len   = chunk_len(mirror);
      total = ((int'(mirror.length) + CHUNK_BYTES - 1) / CHUNK_BYTES) & 8'hFF;
      hdr   = '{cisw_pkg::PKT_MAGIC[15:8], cisw_pkg::PKT_MAGIC[7:0],
                mirror.chunk[15:8], mirror.chunk[7:0],
                8'(mirror.offset >> 8), mirror.offset[7:0], 8'(len), 8'(total),
                mirror_sum[15:8], mirror_sum[7:0]};
      t.kind = 1'b0;
      for (i = 0; i < cisw_pkg::HDR_BYTES + len; i++) begin
        t.pbyte = (i < cisw_pkg::HDR_BYTES) ? hdr[i]
                : img_mem[int'(mirror.offset) + i - cisw_pkg::HDR_BYTES];
        t.last  = (i == cisw_pkg::HDR_BYTES + len - 1);
        tx_awaited_q.push_back(t);
      end
    end else if (c.func == cisw_pkg::FUNC_TICK) begin
      // no packet: a single status result
      t.kind  = 1'b1;
      t.pbyte = '0;
      t.last  = 1'b1;
      tx_awaited_q.push_back(t);
    end
    mirror = nxt;
  endfunction

  // ------------------------------------------------------------------
  // Item construction and queuing
  // ------------------------------------------------------------------

  // Fill every field at random so unused fields toggle too.
  function automatic cmd_t rand_cmd(logic [1:0] f);
    cmd_t c;
    c.func         = f;
    c.reachable    = 1'($urandom_range(0, 1));
    c.ack_number   = 16'($urandom_range(0, 65535));
    c.load_address = 13'($urandom_range(0, IMAGE_DEPTH - 1));
    c.load_byte    = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic cmd_t tick_cmd(logic r);
    cmd_t c;
    c = rand_cmd(cisw_pkg::FUNC_TICK);
    c.reachable = r;
    return c;
  endfunction

  function automatic cmd_t ack_cmd(logic [15:0] n);
    cmd_t c;
    c = rand_cmd(cisw_pkg::FUNC_ACK);
    c.ack_number = n;
    return c;
  endfunction

  function automatic cmd_t load_cmd(logic [12:0] a, logic [7:0] b);
    cmd_t c;
    c = rand_cmd(cisw_pkg::FUNC_LOAD);
    c.load_address = a;
    c.load_byte    = b;
    return c;
  endfunction

  // Queue an item; before any tick that reads the store, load the chunk bytes
  // that were never written so no undefined entry is ever read.
  task automatic queue_cmd(cmd_t c);
    tick_act_e act;
    int        a;
    act = tick_action(plan, c);
    if (act == ACT_SEND || act == ACT_RESEND) begin
      for (a = int'(plan.offset); a < int'(plan.offset) + chunk_len(plan); a++) begin
        if (!loaded[a]) begin
          cmd_q.push_back(load_cmd(13'(a), 8'($urandom_range(0, 255))));
          queued_items++;
          loaded[a] = 1'b1;
        end
      end
    end
    if (c.func == cisw_pkg::FUNC_LOAD) loaded[c.load_address] = 1'b1;
    cmd_q.push_back(c);
    queued_items++;
    plan = next_state(plan, c);
  endtask

  // Hold until every queued item is taken and every result is in, then settle.
  task automatic drain(int settle);
    @(posedge clk_i);
    while (cmd_q.size() != 0 || start || tx_awaited_q.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // Write image_length while the block is idle.
  task automatic write_length(logic [cisw_pkg::LEN_W-1:0] v);
    drain(SETTLE_CYCLES);
    cfg_data_i  <= v;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    mirror.length = v;
    cfg_valid_i  <= 1'b0;
    plan.length   = v;
  endtask

  task automatic note_mismatch(string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) note_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // ------------------------------------------------------------------
  // Driver: present queued items, hold start until taken, idle in bursts
  // ------------------------------------------------------------------
  always @(posedge clk_i) begin : drive_cmds
    logic go;
    if (rst_ni) begin
      go = start;
      if (start && !busy) begin
        // item taken at this edge: predict it, maybe open an idle burst
        predict_tx(cur_cmd);
        go       = 1'b0;
        gap_left = (idle_ok && $urandom_range(0, 3) == 0) ? $urandom_range(1, 12) : 0;
      end
      if (!go) begin
        if (gap_left != 0) begin
          gap_left--;
        end else if (cmd_q.size() != 0) begin
          cur_cmd         = cmd_q.pop_front();
          func_i         <= cur_cmd.func;
          reachable_i    <= cur_cmd.reachable;
          ack_number_i   <= cur_cmd.ack_number;
          load_address_i <= cur_cmd.load_address;
          load_byte_i    <= cur_cmd.load_byte;
          go              = 1'b1;
        end
      end
      start <= go;
    end
  end

  // ------------------------------------------------------------------
  // Monitor: every strobe carries one result; match it against the oldest
  // ------------------------------------------------------------------
  always @(posedge clk_i) begin : watch_tx
    tx_t want;
    if (rst_ni && strobe_o) begin
      if (tx_awaited_q.size() == 0) begin
        note_mismatch("result strobed with nothing expected");
      end else begin
        want = tx_awaited_q.pop_front();
        check_field("kind", kind_o, want.kind);
        check_field("packet_byte", packet_byte_o, want.pbyte);
        check_field("last", last_o, want.last);
        check_field("resend", resend_o, want.resend);
        check_field("transfer_done", transfer_done_o, want.xfer_done);
        check_field("short_wait", short_wait_o, want.short_wait);
        check_field("chunk_number", chunk_number_o, want.chunk);
        check_field("missed_count", missed_count_o, want.misses);
      end
    end
  end

  // ------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------
  initial begin : stimulus
    int                         ph, k, r;
    logic [cisw_pkg::LEN_W-1:0] len_v;
    cmd_t                       c;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Empty image: a reachable tick is already done, an unreachable one at
    // offset zero counts nothing; an ack in the sending state is cleared by send.
    write_length('0);
    queue_cmd(tick_cmd(1'b1));
    queue_cmd(tick_cmd(1'b0));
    queue_cmd(rand_cmd(FUNC_UNUSED));
    queue_cmd(ack_cmd(16'h0000));
    queue_cmd(load_cmd(13'h1FFF, 8'hA5));

    // Five-byte image: send, wrong ack, retry, retry after a store change,
    // matching ack, unreachable tick, advance to done, then done and unreachable ticks.
    write_length(cisw_pkg::LEN_W'(5));
    queue_cmd(load_cmd(13'd0, 8'h00));
    queue_cmd(load_cmd(13'd1, 8'hFF));
    queue_cmd(load_cmd(13'd2, 8'h80));
    queue_cmd(load_cmd(13'd3, 8'h01));
    queue_cmd(load_cmd(13'd4, 8'h7F));
    queue_cmd(tick_cmd(1'b1));
    queue_cmd(ack_cmd(16'hFFFF));
    queue_cmd(tick_cmd(1'b1));
    queue_cmd(load_cmd(13'd2, 8'h3C));
    queue_cmd(tick_cmd(1'b1));
    queue_cmd(ack_cmd(16'h0000));
    queue_cmd(tick_cmd(1'b0));
    queue_cmd(tick_cmd(1'b1));
    queue_cmd(tick_cmd(1'b1));
    queue_cmd(tick_cmd(1'b0));
    queue_cmd(rand_cmd(FUNC_UNUSED));

    // Random phases, each opened by a length write on an idle block. The
    // drain before every write also holds the sender until all results are in.
    // Each phase runs until its share of the item budget is queued.
    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0:       len_v = plan.offset + cisw_pkg::LEN_W'($urandom_range(1, 40));
        1:       len_v = '0;                                   // shrink below offset
        2:       len_v = plan.offset + cisw_pkg::LEN_W'($urandom_range(49, 96));
        3:       len_v = plan.offset;                          // exactly done
        4:       len_v = cisw_pkg::LEN_W'(IMAGE_DEPTH - 1);
        default: len_v = cisw_pkg::LEN_W'(IMAGE_DEPTH);
      endcase
      idle_ok = (ph != 5);                                     // no idling at the end
      write_length(len_v);
      for (k = 0; k < PHASE_MIN || queued_items < ITEM_TARGET * (ph + 1) / 6; k++) begin
        // mostly ticks and matching acks, so chunks keep advancing
        r = $urandom_range(0, 99);
        if (r < 45) begin
          c = tick_cmd(1'b1);
        end else if (r < 75) begin
          c = rand_cmd(cisw_pkg::FUNC_ACK);
          r = $urandom_range(0, 9);
          if (r < 8) c.ack_number = plan.chunk;
          else if (r == 8) c.ack_number = plan.chunk - 1'b1;   // stale ack
        end else if (r < 85) begin
          c = tick_cmd(1'b0);
        end else if (r < 95) begin
          c = rand_cmd(cisw_pkg::FUNC_LOAD);
        end else begin
          c = rand_cmd(FUNC_UNUSED);
        end
        queue_cmd(c);
      end
    end

    drain(TAIL_CYCLES);
    if (mismatches == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  // Guard against a hang: far beyond the slowest correct run.
  initial begin : watchdog
    #20_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/cisw_pkg.sv
hw/rtl/chunked_image_stop_and_wait_sender_unit.sv
tb/sv/tb_top.sv
